### src/prvf_pkg.sv
// ----------------------------------------------------------------------------
// prvf_pkg
// Shared widths, register indexes and reset values for the projected
// rectangle visible-fraction pipeline.
// ----------------------------------------------------------------------------
package prvf_pkg;

   // field widths
   localparam int MAT_W      = 16;
   localparam int DIR_W      = 16;
   localparam int SCR_W      = 14;
   localparam int RECT_W     = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // datapath widths
   localparam int PROD_W     = 32;  // Q1.14 x Q4.12 product
   localparam int CLIP_W     = 33;  // sum of three products
   localparam int LIM_W      = 37;  // 16 * w and clamped coordinate
   localparam int ACC_W      = 38;  // clamped coordinate plus w
   localparam int ONE_R_W    = 11;  // 1 - rect size
   localparam int WR_W       = 44;  // w * (1 - rect size)
   localparam int NUM_W      = 52;  // edge numerator, signed
   localparam int REM_W      = 51;  // numerator magnitude
   localparam int DEN_W      = 33;  // 2 * w
   localparam int QE_W       = 18;  // edge quotient magnitude bits
   localparam int EDGE_W     = 19;  // signed edge
   localparam int EXT_W      = 20;  // edge plus rect size
   localparam int AREA_W     = 18;  // rect area
   localparam int FRAC_SHIFT = 16;  // Q1.16 fraction scale
   localparam int FREM_W     = AREA_W + FRAC_SHIFT;
   localparam int FRAC_W     = 17;  // fraction quotient bits

   // register reset values
   localparam int DIR_X_RESET    = 0;
   localparam int DIR_Y_RESET    = 0;
   localparam int DIR_Z_RESET    = 16384;
   localparam int SCREEN_W_RESET = 1920;
   localparam int SCREEN_H_RESET = 1080;
   localparam int RECT_W_RESET   = 16;
   localparam int RECT_H_RESET   = 16;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIR_X    = 3'd0,
      CSR_DIR_Y    = 3'd1,
      CSR_DIR_Z    = 3'd2,
      CSR_SCREEN_W = 3'd3,
      CSR_SCREEN_H = 3'd4,
      CSR_RECT_W   = 3'd5,
      CSR_RECT_H   = 3'd6
   } csr_index_type;

endpackage

### src/projected_rect_visible_fraction_top.sv
// ----------------------------------------------------------------------------
// projected_rect_visible_fraction_top
// Projects a light direction with three matrix columns, centres a sample
// rectangle on the screen point and reports its visible share of area.
// ----------------------------------------------------------------------------
// The block takes one matrix beat per clock while req_ready is high and returns
// one result beat per matrix, in order. The two pipelined restoring dividers
// compute one quotient bit per stage: 18 stages for the rectangle edges (x and
// y side by side) and 17 stages for the Q1.16 area fraction, plus ten stages
// of multiply, clamp and clip logic. A stall on the result side freezes the
// whole pipeline, and req_ready drops only while a finished result waits.
// Configuration writes are taken at any time (csr_ready is always high) but
// must only be issued while no matrix is in flight. Screen and rectangle
// sizes above SCREEN_MAX and RECT_MAX are held at those limits.
// ----------------------------------------------------------------------------
module projected_rect_visible_fraction_top #(
   parameter int RECT_MAX   = 256,
   parameter int SCREEN_MAX = 8192
) (
   input  logic                                clock,
   input  logic                                reset,
   // matrix beats
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_mx_row0,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_mx_row1,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_mx_row2,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_my_row0,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_my_row1,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_my_row2,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_mw_row0,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_mw_row1,
   input  logic signed [prvf_pkg::MAT_W-1:0]   req_mw_row2,
   // result beats
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [prvf_pkg::FRAC_W-1:0]         rsp_visible_fraction,
   output logic                                rsp_behind_viewer,
   output logic                                rsp_ratio_saturated,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [prvf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [prvf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SCR_W  = prvf_pkg::SCR_W;
   localparam int RECT_W = prvf_pkg::RECT_W;
   localparam int QE_W   = prvf_pkg::QE_W;
   localparam int FQ_W   = prvf_pkg::FRAC_W;

   localparam logic [SCR_W-1:0] SW_RESET = SCR_W'(
      (prvf_pkg::SCREEN_W_RESET > SCREEN_MAX) ? SCREEN_MAX : prvf_pkg::SCREEN_W_RESET);
   localparam logic [SCR_W-1:0] SH_RESET = SCR_W'(
      (prvf_pkg::SCREEN_H_RESET > SCREEN_MAX) ? SCREEN_MAX : prvf_pkg::SCREEN_H_RESET);
   localparam logic [RECT_W-1:0] RW_RESET = RECT_W'(
      (prvf_pkg::RECT_W_RESET > RECT_MAX) ? RECT_MAX : prvf_pkg::RECT_W_RESET);
   localparam logic [RECT_W-1:0] RH_RESET = RECT_W'(
      (prvf_pkg::RECT_H_RESET > RECT_MAX) ? RECT_MAX : prvf_pkg::RECT_H_RESET);

   // ------------------------------------------------------------------------
   // configuration registers, sizes stored already capped
   // ------------------------------------------------------------------------
   logic signed [prvf_pkg::DIR_W-1:0] dir_ff [3];
   logic [SCR_W-1:0]                  sw_ff;
   logic [SCR_W-1:0]                  sh_ff;
   logic [RECT_W-1:0]                 rw_ff;
   logic [RECT_W-1:0]                 rh_ff;
   logic [SCR_W-1:0]                  scr_cap_in;
   logic [RECT_W-1:0]                 rect_cap_in;

   assign csr_ready = 1'b1;

   // cap written sizes at the limits
   assign scr_cap_in  = (csr_data[SCR_W-1:0] > SCREEN_MAX) ? SCR_W'(SCREEN_MAX)
                                                          : csr_data[SCR_W-1:0];
   assign rect_cap_in = (csr_data[RECT_W-1:0] > RECT_MAX) ? RECT_W'(RECT_MAX)
                                                         : csr_data[RECT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff[0] <= prvf_pkg::DIR_W'(prvf_pkg::DIR_X_RESET);
         dir_ff[1] <= prvf_pkg::DIR_W'(prvf_pkg::DIR_Y_RESET);
         dir_ff[2] <= prvf_pkg::DIR_W'(prvf_pkg::DIR_Z_RESET);
         sw_ff     <= SW_RESET;
         sh_ff     <= SH_RESET;
         rw_ff     <= RW_RESET;
         rh_ff     <= RH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (prvf_pkg::csr_index_type'(csr_index))
            prvf_pkg::CSR_DIR_X:    dir_ff[0] <= csr_data;
            prvf_pkg::CSR_DIR_Y:    dir_ff[1] <= csr_data;
            prvf_pkg::CSR_DIR_Z:    dir_ff[2] <= csr_data;
            prvf_pkg::CSR_SCREEN_W: sw_ff     <= scr_cap_in;
            prvf_pkg::CSR_SCREEN_H: sh_ff     <= scr_cap_in;
            prvf_pkg::CSR_RECT_W:   rw_ff     <= rect_cap_in;
            prvf_pkg::CSR_RECT_H:   rh_ff     <= rect_cap_in;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // pipeline advance: everything moves unless a result waits
   // ------------------------------------------------------------------------
   logic adv;
   logic fv_ff [FQ_W+1];

   assign adv       = !fv_ff[FQ_W] || rsp_ready;
   assign req_ready = adv;

   // ------------------------------------------------------------------------
   // stage 1: nine products, column c row r times direction r
   // ------------------------------------------------------------------------
   logic signed [prvf_pkg::MAT_W-1:0]  mtx [3][3];
   logic signed [prvf_pkg::PROD_W-1:0] prod_in [3][3];
   logic signed [prvf_pkg::PROD_W-1:0] prod_ff [3][3];
   logic                               s1_v_ff;

   assign mtx[0][0] = req_mx_row0;
   assign mtx[0][1] = req_mx_row1;
   assign mtx[0][2] = req_mx_row2;
   assign mtx[1][0] = req_my_row0;
   assign mtx[1][1] = req_my_row1;
   assign mtx[1][2] = req_my_row2;
   assign mtx[2][0] = req_mw_row0;
   assign mtx[2][1] = req_mw_row1;
   assign mtx[2][2] = req_mw_row2;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            prod_in[c][r] = mtx[c][r] * dir_ff[r];
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: clip x, y, w
   // ------------------------------------------------------------------------
   logic signed [prvf_pkg::CLIP_W-1:0] clip_in [3];
   logic signed [prvf_pkg::CLIP_W-1:0] clip_ff [3];
   logic                               s2_v_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         clip_in[c] = prvf_pkg::CLIP_W'(prod_ff[c][0]) + prvf_pkg::CLIP_W'(prod_ff[c][1])
                    + prvf_pkg::CLIP_W'(prod_ff[c][2]);
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: behind test, clamp to +-16 w, add w
   // ------------------------------------------------------------------------
   logic signed [prvf_pkg::LIM_W-1:0]  lim;
   logic signed [prvf_pkg::LIM_W-1:0]  pxe;
   logic signed [prvf_pkg::LIM_W-1:0]  pye;
   logic signed [prvf_pkg::LIM_W-1:0]  pxc;
   logic signed [prvf_pkg::LIM_W-1:0]  pyc;
   logic                               satx;
   logic                               saty;
   logic                               s3_beh_in;
   logic signed [prvf_pkg::ACC_W-1:0]  ax_in;
   logic signed [prvf_pkg::ACC_W-1:0]  ay_in;
   logic signed [prvf_pkg::ACC_W-1:0]  ax_ff;
   logic signed [prvf_pkg::ACC_W-1:0]  ay_ff;
   logic signed [prvf_pkg::CLIP_W-1:0] s3_w_ff;
   logic                               s3_beh_ff;
   logic                               s3_sat_ff;
   logic                               s3_v_ff;

   always_comb begin
      lim       = $signed({clip_ff[2], 4'b0000});
      pxe       = prvf_pkg::LIM_W'(clip_ff[0]);
      pye       = prvf_pkg::LIM_W'(clip_ff[1]);
      s3_beh_in = (clip_ff[2] <= 0);
      satx      = 1'b0;
      saty      = 1'b0;
      pxc       = pxe;
      pyc       = pye;
      priority if (pxe > lim) begin
         pxc  = lim;
         satx = 1'b1;
      end else if (pxe < -lim) begin
         pxc  = -lim;
         satx = 1'b1;
      end
      priority if (pye > lim) begin
         pyc  = lim;
         saty = 1'b1;
      end else if (pye < -lim) begin
         pyc  = -lim;
         saty = 1'b1;
      end
      ax_in = prvf_pkg::ACC_W'(pxc) + prvf_pkg::ACC_W'(clip_ff[2]);
      ay_in = prvf_pkg::ACC_W'(pyc) + prvf_pkg::ACC_W'(clip_ff[2]);
   end

   // ------------------------------------------------------------------------
   // stage 4: (p + w) * S and w * (1 - R) per axis
   // ------------------------------------------------------------------------
   logic signed [SCR_W:0]               sw_sgn;
   logic signed [SCR_W:0]               sh_sgn;
   logic signed [prvf_pkg::ONE_R_W-1:0] omrw;
   logic signed [prvf_pkg::ONE_R_W-1:0] omrh;
   logic signed [prvf_pkg::NUM_W-1:0]   mulx_in;
   logic signed [prvf_pkg::NUM_W-1:0]   muly_in;
   logic signed [prvf_pkg::WR_W-1:0]    wrx_in;
   logic signed [prvf_pkg::WR_W-1:0]    wry_in;
   logic signed [prvf_pkg::NUM_W-1:0]   mulx_ff;
   logic signed [prvf_pkg::NUM_W-1:0]   muly_ff;
   logic signed [prvf_pkg::WR_W-1:0]    wrx_ff;
   logic signed [prvf_pkg::WR_W-1:0]    wry_ff;
   logic signed [prvf_pkg::CLIP_W-1:0]  s4_w_ff;
   logic                                s4_beh_ff;
   logic                                s4_sat_ff;
   logic                                s4_v_ff;

   assign sw_sgn  = $signed({1'b0, sw_ff});
   assign sh_sgn  = $signed({1'b0, sh_ff});
   assign omrw    = prvf_pkg::ONE_R_W'(1) - $signed(prvf_pkg::ONE_R_W'(rw_ff));
   assign omrh    = prvf_pkg::ONE_R_W'(1) - $signed(prvf_pkg::ONE_R_W'(rh_ff));
   assign mulx_in = ax_ff * sw_sgn;
   assign muly_in = ay_ff * sh_sgn;
   assign wrx_in  = s3_w_ff * omrw;
   assign wry_in  = s3_w_ff * omrh;

   // ------------------------------------------------------------------------
   // stage 5: edge numerators
   // ------------------------------------------------------------------------
   logic signed [prvf_pkg::NUM_W-1:0]  nx_ff;
   logic signed [prvf_pkg::NUM_W-1:0]  ny_ff;
   logic signed [prvf_pkg::CLIP_W-1:0] s5_w_ff;
   logic                               s5_beh_ff;
   logic                               s5_sat_ff;
   logic                               s5_v_ff;

   // ------------------------------------------------------------------------
   // edge divider: entry stage takes magnitudes, then one quotient bit
   // per stage, x and y share the divisor 2 w
   // ------------------------------------------------------------------------
   logic [prvf_pkg::REM_W-1:0] drx_in [QE_W+1];
   logic [prvf_pkg::REM_W-1:0] dry_in [QE_W+1];
   logic [prvf_pkg::DEN_W-1:0] dden_in [QE_W+1];
   logic [QE_W-1:0]            dqx_in [QE_W+1];
   logic [QE_W-1:0]            dqy_in [QE_W+1];
   logic                       dnx_in [QE_W+1];
   logic                       dny_in [QE_W+1];
   logic                       dbeh_in [QE_W+1];
   logic                       dsat_in [QE_W+1];
   logic                       dv_in [QE_W+1];
   logic [prvf_pkg::REM_W-1:0] drx_ff [QE_W+1];
   logic [prvf_pkg::REM_W-1:0] dry_ff [QE_W+1];
   logic [prvf_pkg::DEN_W-1:0] dden_ff [QE_W+1];
   logic [QE_W-1:0]            dqx_ff [QE_W+1];
   logic [QE_W-1:0]            dqy_ff [QE_W+1];
   logic                       dnx_ff [QE_W+1];
   logic                       dny_ff [QE_W+1];
   logic                       dbeh_ff [QE_W+1];
   logic                       dsat_ff [QE_W+1];
   logic                       dv_ff [QE_W+1];
   logic [prvf_pkg::REM_W-1:0] dtrial [QE_W];

   always_comb begin
      // entry: sign and magnitude, divisor 2 w
      drx_in[0]  = nx_ff[prvf_pkg::NUM_W-1] ? prvf_pkg::REM_W'(-nx_ff)
                                            : prvf_pkg::REM_W'(nx_ff);
      dry_in[0]  = ny_ff[prvf_pkg::NUM_W-1] ? prvf_pkg::REM_W'(-ny_ff)
                                            : prvf_pkg::REM_W'(ny_ff);
      dnx_in[0]  = nx_ff[prvf_pkg::NUM_W-1];
      dny_in[0]  = ny_ff[prvf_pkg::NUM_W-1];
      dden_in[0] = {s5_w_ff[prvf_pkg::DEN_W-2:0], 1'b0};
      dqx_in[0]  = '0;
      dqy_in[0]  = '0;
      dbeh_in[0] = s5_beh_ff;
      dsat_in[0] = s5_sat_ff;
      dv_in[0]   = s5_v_ff;
      // restoring steps, most significant quotient bit first
      for (int j = 0; j < QE_W; j++) begin
         dtrial[j]    = prvf_pkg::REM_W'(dden_ff[j]) << (QE_W - 1 - j);
         drx_in[j+1]  = drx_ff[j];
         dry_in[j+1]  = dry_ff[j];
         dqx_in[j+1]  = dqx_ff[j];
         dqy_in[j+1]  = dqy_ff[j];
         if (drx_ff[j] >= dtrial[j]) begin
            drx_in[j+1] = drx_ff[j] - dtrial[j];
            dqx_in[j+1] = dqx_ff[j] | (QE_W'(1) << (QE_W - 1 - j));
         end
         if (dry_ff[j] >= dtrial[j]) begin
            dry_in[j+1] = dry_ff[j] - dtrial[j];
            dqy_in[j+1] = dqy_ff[j] | (QE_W'(1) << (QE_W - 1 - j));
         end
         dden_in[j+1] = dden_ff[j];
         dnx_in[j+1]  = dnx_ff[j];
         dny_in[j+1]  = dny_ff[j];
         dbeh_in[j+1] = dbeh_ff[j];
         dsat_in[j+1] = dsat_ff[j];
         dv_in[j+1]   = dv_ff[j];
      end
   end

   // ------------------------------------------------------------------------
   // edge stage 1: signed low edges, truncated toward zero
   // ------------------------------------------------------------------------
   logic signed [prvf_pkg::EDGE_W-1:0] lx_in;
   logic signed [prvf_pkg::EDGE_W-1:0] ly_in;
   logic signed [prvf_pkg::EDGE_W-1:0] lx_ff;
   logic signed [prvf_pkg::EDGE_W-1:0] ly_ff;
   logic                               e1_beh_ff;
   logic                               e1_sat_ff;
   logic                               e1_v_ff;

   assign lx_in = dnx_ff[QE_W] ? -$signed(prvf_pkg::EDGE_W'(dqx_ff[QE_W]))
                               :  $signed(prvf_pkg::EDGE_W'(dqx_ff[QE_W]));
   assign ly_in = dny_ff[QE_W] ? -$signed(prvf_pkg::EDGE_W'(dqy_ff[QE_W]))
                               :  $signed(prvf_pkg::EDGE_W'(dqy_ff[QE_W]));

   // ------------------------------------------------------------------------
   // edge stage 2: clip low edge at 0 and high edge at the screen size
   // ------------------------------------------------------------------------
   logic signed [prvf_pkg::EXT_W-1:0] rw_ext;
   logic signed [prvf_pkg::EXT_W-1:0] rh_ext;
   logic signed [prvf_pkg::EXT_W-1:0] sw_ext;
   logic signed [prvf_pkg::EXT_W-1:0] sh_ext;
   logic signed [prvf_pkg::EXT_W-1:0] hx;
   logic signed [prvf_pkg::EXT_W-1:0] hy;
   logic signed [prvf_pkg::EXT_W-1:0] lcx_in;
   logic signed [prvf_pkg::EXT_W-1:0] lcy_in;
   logic signed [prvf_pkg::EXT_W-1:0] hcx_in;
   logic signed [prvf_pkg::EXT_W-1:0] hcy_in;
   logic signed [prvf_pkg::EXT_W-1:0] lcx_ff;
   logic signed [prvf_pkg::EXT_W-1:0] lcy_ff;
   logic signed [prvf_pkg::EXT_W-1:0] hcx_ff;
   logic signed [prvf_pkg::EXT_W-1:0] hcy_ff;
   logic                              e2_beh_ff;
   logic                              e2_sat_ff;
   logic                              e2_v_ff;

   assign rw_ext = $signed(prvf_pkg::EXT_W'(rw_ff));
   assign rh_ext = $signed(prvf_pkg::EXT_W'(rh_ff));
   assign sw_ext = $signed(prvf_pkg::EXT_W'(sw_ff));
   assign sh_ext = $signed(prvf_pkg::EXT_W'(sh_ff));
   assign hx     = prvf_pkg::EXT_W'(lx_ff) + rw_ext;
   assign hy     = prvf_pkg::EXT_W'(ly_ff) + rh_ext;
   assign lcx_in = (lx_ff < 0) ? '0 : prvf_pkg::EXT_W'(lx_ff);
   assign lcy_in = (ly_ff < 0) ? '0 : prvf_pkg::EXT_W'(ly_ff);
   assign hcx_in = (hx > sw_ext) ? sw_ext : hx;
   assign hcy_in = (hy > sh_ext) ? sh_ext : hy;

   // ------------------------------------------------------------------------
   // edge stage 3: visible extents, never wider than the rectangle
   // ------------------------------------------------------------------------
   logic [RECT_W-1:0] wx_in;
   logic [RECT_W-1:0] wy_in;
   logic [RECT_W-1:0] wx_ff;
   logic [RECT_W-1:0] wy_ff;
   logic              e3_beh_ff;
   logic              e3_sat_ff;
   logic              e3_v_ff;

   assign wx_in = (hcx_ff > lcx_ff) ? RECT_W'(hcx_ff - lcx_ff) : '0;
   assign wy_in = (hcy_ff > lcy_ff) ? RECT_W'(hcy_ff - lcy_ff) : '0;

   // ------------------------------------------------------------------------
   // fraction divider: entry stage forms area << 16, then one bit per stage
   // ------------------------------------------------------------------------
   logic [prvf_pkg::AREA_W-1:0] full;
   logic                        full_zero;
   logic [prvf_pkg::AREA_W-1:0] area;
   logic [prvf_pkg::FREM_W-1:0] frem_in [FQ_W+1];
   logic [FQ_W-1:0]             fq_in [FQ_W+1];
   logic                        fbeh_in [FQ_W+1];
   logic                        fsat_in [FQ_W+1];
   logic                        fv_in [FQ_W+1];
   logic [prvf_pkg::FREM_W-1:0] frem_ff [FQ_W+1];
   logic [FQ_W-1:0]             fq_ff [FQ_W+1];
   logic                        fbeh_ff [FQ_W+1];
   logic                        fsat_ff [FQ_W+1];
   logic [prvf_pkg::FREM_W-1:0] ftrial [FQ_W];

   assign full      = prvf_pkg::AREA_W'(rw_ff) * prvf_pkg::AREA_W'(rh_ff);
   assign full_zero = (full == '0);
   assign area      = prvf_pkg::AREA_W'(wx_ff) * prvf_pkg::AREA_W'(wy_ff);

   always_comb begin
      // entry: nothing visible when behind the viewer
      frem_in[0] = e3_beh_ff ? '0 : {area, {prvf_pkg::FRAC_SHIFT{1'b0}}};
      fq_in[0]   = '0;
      fbeh_in[0] = e3_beh_ff;
      fsat_in[0] = e3_sat_ff;
      fv_in[0]   = e3_v_ff;
      for (int j = 0; j < FQ_W; j++) begin
         ftrial[j]    = prvf_pkg::FREM_W'(full) << (FQ_W - 1 - j);
         frem_in[j+1] = frem_ff[j];
         fq_in[j+1]   = fq_ff[j];
         if (frem_ff[j] >= ftrial[j]) begin
            frem_in[j+1] = frem_ff[j] - ftrial[j];
            fq_in[j+1]   = fq_ff[j] | (FQ_W'(1) << (FQ_W - 1 - j));
         end
         fbeh_in[j+1] = fbeh_ff[j];
         fsat_in[j+1] = fsat_ff[j];
         fv_in[j+1]   = fv_ff[j];
      end
   end

   // ------------------------------------------------------------------------
   // valid bits
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
         e3_v_ff <= 1'b0;
         for (int k = 0; k <= QE_W; k++) begin
            dv_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= FQ_W; k++) begin
            fv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         e1_v_ff <= dv_ff[QE_W];
         e2_v_ff <= e1_v_ff;
         e3_v_ff <= e2_v_ff;
         for (int k = 0; k <= QE_W; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         for (int k = 0; k <= FQ_W; k++) begin
            fv_ff[k] <= fv_in[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         clip_ff   <= clip_in;
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         s3_w_ff   <= clip_ff[2];
         s3_beh_ff <= s3_beh_in;
         s3_sat_ff <= (satx || saty) && !s3_beh_in;
         mulx_ff   <= mulx_in;
         muly_ff   <= muly_in;
         wrx_ff    <= wrx_in;
         wry_ff    <= wry_in;
         s4_w_ff   <= s3_w_ff;
         s4_beh_ff <= s3_beh_ff;
         s4_sat_ff <= s3_sat_ff;
         nx_ff     <= mulx_ff + prvf_pkg::NUM_W'(wrx_ff);
         ny_ff     <= muly_ff + prvf_pkg::NUM_W'(wry_ff);
         s5_w_ff   <= s4_w_ff;
         s5_beh_ff <= s4_beh_ff;
         s5_sat_ff <= s4_sat_ff;
         for (int k = 0; k <= QE_W; k++) begin
            drx_ff[k]  <= drx_in[k];
            dry_ff[k]  <= dry_in[k];
            dden_ff[k] <= dden_in[k];
            dqx_ff[k]  <= dqx_in[k];
            dqy_ff[k]  <= dqy_in[k];
            dnx_ff[k]  <= dnx_in[k];
            dny_ff[k]  <= dny_in[k];
            dbeh_ff[k] <= dbeh_in[k];
            dsat_ff[k] <= dsat_in[k];
         end
         lx_ff     <= lx_in;
         ly_ff     <= ly_in;
         e1_beh_ff <= dbeh_ff[QE_W];
         e1_sat_ff <= dsat_ff[QE_W];
         lcx_ff    <= lcx_in;
         lcy_ff    <= lcy_in;
         hcx_ff    <= hcx_in;
         hcy_ff    <= hcy_in;
         e2_beh_ff <= e1_beh_ff;
         e2_sat_ff <= e1_sat_ff;
         wx_ff     <= wx_in;
         wy_ff     <= wy_in;
         e3_beh_ff <= e2_beh_ff;
         e3_sat_ff <= e2_sat_ff;
         for (int k = 0; k <= FQ_W; k++) begin
            frem_ff[k] <= frem_in[k];
            fq_ff[k]   <= fq_in[k];
            fbeh_ff[k] <= fbeh_in[k];
            fsat_ff[k] <= fsat_in[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // result beat, empty rectangle gives zero
   // ------------------------------------------------------------------------
   assign rsp_valid            = fv_ff[FQ_W];
   assign rsp_visible_fraction = full_zero ? '0 : fq_ff[FQ_W];
   assign rsp_behind_viewer    = fbeh_ff[FQ_W];
   assign rsp_ratio_saturated  = fsat_ff[FQ_W];

`ifndef SYNTHESIS
   // behind the viewer means no area and no saturation
   a_behind_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_behind_viewer |-> rsp_visible_fraction == '0 && !rsp_ratio_saturated)
      else $error("behind-viewer result carries area or saturation");

   // fraction never exceeds one whole
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_visible_fraction <= FQ_W'(1 << prvf_pkg::FRAC_SHIFT))
      else $error("visible fraction above one");

   // edge divider leaves a remainder below the divisor
   a_edge_rem: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QE_W] && !dbeh_ff[QE_W] |->
         drx_ff[QE_W] < prvf_pkg::REM_W'(dden_ff[QE_W]) &&
         dry_ff[QE_W] < prvf_pkg::REM_W'(dden_ff[QE_W]))
      else $error("edge quotient overflow");

   // clipped extents stay within the rectangle
   a_extent: assert property (@(posedge clock) disable iff (reset)
      e3_v_ff |-> wx_ff <= rw_ff && wy_ff <= rh_ff)
      else $error("visible extent wider than rectangle");

   // fraction divider leaves a remainder below the rectangle area
   a_frac_rem: assert property (@(posedge clock) disable iff (reset)
      fv_ff[FQ_W] && !full_zero |-> frem_ff[FQ_W] < prvf_pkg::FREM_W'(full))
      else $error("fraction quotient overflow");
`endif

endmodule

### bench/tb_projected_rect_visible_fraction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_projected_rect_visible_fraction_top
// Self-checking bench for the projected rectangle visible-fraction block.
// Matrix beats come from a backlog that the stimulus process fills. For each
// accepted beat, a local copy of the register file predicts the result. The
// monitor compares each returned beat with the oldest prediction. Register
// settings change only between phases, once every result is back. The first
// phase is hand-picked. Later phases aim the projected point at the centre,
// the edges and far off screen, with some raw noise mixed in.
// ----------------------------------------------------------------------------
module tb_projected_rect_visible_fraction_top;
   import prvf_pkg::*;

   localparam int RECT_LIMIT   = 256;
   localparam int SCREEN_LIMIT = 8192;
   localparam int RANDOM_PHASES = 22;
   localparam int RANDOM_BEATS  = 78;
   localparam int SPECIAL_BEATS = 30;
   localparam int IDLE_PCT      = 19;
   localparam longint ONE_Q12   = 4096;
   localparam longint FULL_FRAC = 65536;
   // index past the last register, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic signed [MAT_W-1:0] mx_row0;
      logic signed [MAT_W-1:0] mx_row1;
      logic signed [MAT_W-1:0] mx_row2;
      logic signed [MAT_W-1:0] my_row0;
      logic signed [MAT_W-1:0] my_row1;
      logic signed [MAT_W-1:0] my_row2;
      logic signed [MAT_W-1:0] mw_row0;
      logic signed [MAT_W-1:0] mw_row1;
      logic signed [MAT_W-1:0] mw_row2;
   } matrix_beat_t;

   typedef struct packed {
      logic [FRAC_W-1:0] fraction;
      logic              behind;
      logic              clamped;
   } view_result_t;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_t;

   logic clock;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [MAT_W-1:0] req_mx_row0 = '0;
   logic signed [MAT_W-1:0] req_mx_row1 = '0;
   logic signed [MAT_W-1:0] req_mx_row2 = '0;
   logic signed [MAT_W-1:0] req_my_row0 = '0;
   logic signed [MAT_W-1:0] req_my_row1 = '0;
   logic signed [MAT_W-1:0] req_my_row2 = '0;
   logic signed [MAT_W-1:0] req_mw_row0 = '0;
   logic signed [MAT_W-1:0] req_mw_row1 = '0;
   logic signed [MAT_W-1:0] req_mw_row2 = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [FRAC_W-1:0] rsp_visible_fraction;
   logic              rsp_behind_viewer;
   logic              rsp_ratio_saturated;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // local copy of the register file
   logic signed [DIR_W-1:0] dir_x_q  = DIR_X_RESET;
   logic signed [DIR_W-1:0] dir_y_q  = DIR_Y_RESET;
   logic signed [DIR_W-1:0] dir_z_q  = DIR_Z_RESET;
   logic [SCR_W-1:0]        scr_w_q  = SCREEN_W_RESET;
   logic [SCR_W-1:0]        scr_h_q  = SCREEN_H_RESET;
   logic [RECT_W-1:0]       rect_w_q = RECT_W_RESET;
   logic [RECT_W-1:0]       rect_h_q = RECT_H_RESET;

   matrix_beat_t matrix_backlog[$];
   view_result_t expected_views[$];
   reg_write_t   reg_writes[$];
   matrix_beat_t drv_beat;

   int sender_idle_pct   = IDLE_PCT;
   int receiver_idle_pct = IDLE_PCT;
   int beats_queued   = 0;
   int beats_accepted = 0;
   int results_seen   = 0;
   int writes_queued  = 0;
   int writes_taken   = 0;
   int settings_used  = 0;
   int behind_count   = 0;
   int clamp_count    = 0;
   int partial_count  = 0;
   int error_count    = 0;

   projected_rect_visible_fraction_top #(
      .RECT_MAX   (RECT_LIMIT),
      .SCREEN_MAX (SCREEN_LIMIT)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mx_row0          (req_mx_row0),
      .req_mx_row1          (req_mx_row1),
      .req_mx_row2          (req_mx_row2),
      .req_my_row0          (req_my_row0),
      .req_my_row1          (req_my_row1),
      .req_my_row2          (req_my_row2),
      .req_mw_row0          (req_mw_row0),
      .req_mw_row1          (req_mw_row1),
      .req_mw_row2          (req_mw_row2),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_visible_fraction (rsp_visible_fraction),
      .rsp_behind_viewer    (rsp_behind_viewer),
      .rsp_ratio_saturated  (rsp_ratio_saturated),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("[projected_rect_visible_fraction_top] ERROR");
      $finish;
   end

   // register write into the local copy, sizes keep only their port bits
   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_DIR_X:    dir_x_q  = data;
         CSR_DIR_Y:    dir_y_q  = data;
         CSR_DIR_Z:    dir_z_q  = data;
         CSR_SCREEN_W: scr_w_q  = data[SCR_W-1:0];
         CSR_SCREEN_H: scr_h_q  = data[SCR_W-1:0];
         CSR_RECT_W:   rect_w_q = data[RECT_W-1:0];
         CSR_RECT_H:   rect_h_q = data[RECT_W-1:0];
         default: ;
      endcase
   endfunction

   // clamp a clip coordinate to +-16 w
   function automatic longint clamp_clip(longint p, longint w);
      longint lim;
      lim = 16 * w;
      if (p > lim) return lim;
      if (p < -lim) return -lim;
      return p;
   endfunction

   // low edge of the centred rectangle, rounded half up then toward zero
   function automatic longint low_edge(longint p, longint w, longint scr, longint sz);
      return (p * scr + w * scr - sz * w + w) / (2 * w);
   endfunction

   // visible share of the sample rectangle for one matrix beat
   function automatic view_result_t predict_view(matrix_beat_t m);
      longint dx, dy, dz, px, py, pw, cx, cy, sw, sh, rw, rh;
      longint lft, top, rgt, bot, area, full, frac;
      view_result_t res;
      dx = longint'(dir_x_q);
      dy = longint'(dir_y_q);
      dz = longint'(dir_z_q);
      px = dx * longint'(m.mx_row0) + dy * longint'(m.mx_row1) + dz * longint'(m.mx_row2);
      py = dx * longint'(m.my_row0) + dy * longint'(m.my_row1) + dz * longint'(m.my_row2);
      pw = dx * longint'(m.mw_row0) + dy * longint'(m.mw_row1) + dz * longint'(m.mw_row2);
      sw = (scr_w_q > SCREEN_LIMIT) ? SCREEN_LIMIT : longint'(scr_w_q);
      sh = (scr_h_q > SCREEN_LIMIT) ? SCREEN_LIMIT : longint'(scr_h_q);
      rw = (rect_w_q > RECT_LIMIT) ? RECT_LIMIT : longint'(rect_w_q);
      rh = (rect_h_q > RECT_LIMIT) ? RECT_LIMIT : longint'(rect_h_q);
      res = '0;
      if (pw <= 0) begin
         res.behind = 1'b1;
      end else begin
         cx = clamp_clip(px, pw);
         cy = clamp_clip(py, pw);
         res.clamped = (cx != px) || (cy != py);
         lft = low_edge(cx, pw, sw, rw);
         top = low_edge(cy, pw, sh, rh);
         rgt = lft + rw;
         bot = top + rh;
         if (lft < 0) lft = 0;
         if (top < 0) top = 0;
         if (rgt > sw) rgt = sw;
         if (bot > sh) bot = sh;
         frac = 0;
         full = rw * rh;
         if (rgt > lft && bot > top && full != 0) begin
            area = (rgt - lft) * (bot - top);
            frac = (area << 16) / full;
         end
         res.fraction = frac[FRAC_W-1:0];
      end
      return res;
   endfunction

   // matrix beat driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_views.push_back(predict_view(drv_beat));
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (matrix_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               drv_beat = matrix_backlog.pop_front();
               req_mx_row0 <= drv_beat.mx_row0;
               req_mx_row1 <= drv_beat.mx_row1;
               req_mx_row2 <= drv_beat.mx_row2;
               req_my_row0 <= drv_beat.my_row0;
               req_my_row1 <= drv_beat.my_row1;
               req_my_row2 <= drv_beat.my_row2;
               req_mw_row0 <= drv_beat.mw_row0;
               req_mw_row1 <= drv_beat.mw_row1;
               req_mw_row2 <= drv_beat.mw_row2;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      reg_write_t wr;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_reg_write(csr_index, csr_data);
            writes_taken++;
         end
         if (!csr_valid || csr_ready) begin
            if (reg_writes.size() != 0) begin
               wr = reg_writes.pop_front();
               csr_index <= wr.index;
               csr_data  <= wr.data;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      view_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_behind_viewer) behind_count++;
         if (rsp_ratio_saturated) clamp_count++;
         if (rsp_visible_fraction != 0 && rsp_visible_fraction != FULL_FRAC) partial_count++;
         if (expected_views.size() == 0) begin
            $display("%0t: result beat with nothing expected: fraction %0d behind %0d clamp %0d",
                     $time, rsp_visible_fraction, rsp_behind_viewer, rsp_ratio_saturated);
            error_count++;
         end else begin
            want = expected_views.pop_front();
            if (rsp_visible_fraction !== want.fraction) begin
               $display("%0t: visible_fraction expected %0d actual %0d",
                        $time, want.fraction, rsp_visible_fraction);
               error_count++;
            end
            if (rsp_behind_viewer !== want.behind) begin
               $display("%0t: behind_viewer expected %0d actual %0d",
                        $time, want.behind, rsp_behind_viewer);
               error_count++;
            end
            if (rsp_ratio_saturated !== want.clamped) begin
               $display("%0t: ratio_saturated expected %0d actual %0d",
                        $time, want.clamped, rsp_ratio_saturated);
               error_count++;
            end
         end
      end
   end

   function automatic longint rand_signed(int limit);
      return longint'($urandom_range(2 * limit)) - limit;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // clip ratio to aim at, Q12: centre area, near an edge, or around and past the clamp
   function automatic longint aim_target(longint scr, longint rect, bit wild);
      longint margin, t;
      if (scr < 16) scr = 16;
      margin = (8192 * rect) / scr + 4;
      if (wild) begin
         t = longint'($urandom_range(90000, 60000));
         if ($urandom_range(1) != 0) t = -t;
      end else if ($urandom_range(1) != 0) begin
         t = rand_signed(5000);
      end else begin
         t = (($urandom_range(1) != 0) ? ONE_Q12 : -ONE_Q12) + rand_signed(int'(margin));
      end
      return t;
   endfunction

   // solve the dominant row so the column projects to about t * w
   function automatic void aim_column(input longint d[3], input int k, input longint pw,
                                      input longint t, output longint col[3]);
      longint rest;
      rest = 0;
      for (int i = 0; i < 3; i++) begin
         col[i] = rand_signed(2048);
         if (i != k) rest += d[i] * col[i];
      end
      col[k] = clamp16(((pw * t) / ONE_Q12 - rest) / d[k]);
   endfunction

   // one random matrix beat, mostly aimed at the interesting screen areas
   function automatic matrix_beat_t make_matrix();
      longint d[3];
      longint wcol[3], xcol[3], ycol[3];
      longint pw;
      logic [159:0] raw;
      int k, pick;
      matrix_beat_t m;
      d[0] = longint'(dir_x_q);
      d[1] = longint'(dir_y_q);
      d[2] = longint'(dir_z_q);
      k = 0;
      for (int i = 1; i < 3; i++) begin
         if ((d[i] < 0 ? -d[i] : d[i]) > (d[k] < 0 ? -d[k] : d[k])) k = i;
      end
      pick = $urandom_range(99);
      if (pick < 20 || d[k] == 0) begin
         raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         m = raw[$bits(matrix_beat_t)-1:0];
      end else begin
         for (int i = 0; i < 3; i++) wcol[i] = rand_signed(256);
         // tiny w lands close to the behind-viewer boundary
         wcol[k] = (pick < 30) ? longint'($urandom_range(64, 1))
                               : longint'($urandom_range(24000, 4096));
         if (d[k] < 0) wcol[k] = -wcol[k];
         pw = d[0] * wcol[0] + d[1] * wcol[1] + d[2] * wcol[2];
         aim_column(d, k, pw, aim_target(scr_w_q, rect_w_q, pick >= 90), xcol);
         aim_column(d, k, pw, aim_target(scr_h_q, rect_h_q, pick >= 90), ycol);
         m.mx_row0 = xcol[0][MAT_W-1:0];
         m.mx_row1 = xcol[1][MAT_W-1:0];
         m.mx_row2 = xcol[2][MAT_W-1:0];
         m.my_row0 = ycol[0][MAT_W-1:0];
         m.my_row1 = ycol[1][MAT_W-1:0];
         m.my_row2 = ycol[2][MAT_W-1:0];
         m.mw_row0 = wcol[0][MAT_W-1:0];
         m.mw_row1 = wcol[1][MAT_W-1:0];
         m.mw_row2 = wcol[2][MAT_W-1:0];
      end
      return m;
   endfunction

   // beat for the reset direction (pure z): only row 2 matters
   function automatic matrix_beat_t z_beat(int mx, int my, int mw);
      matrix_beat_t m;
      logic [159:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      m = raw[$bits(matrix_beat_t)-1:0];
      m.mx_row2 = MAT_W'(mx);
      m.my_row2 = MAT_W'(my);
      m.mw_row2 = MAT_W'(mw);
      return m;
   endfunction

   task automatic queue_beat(matrix_beat_t m);
      matrix_backlog.push_back(m);
      beats_queued++;
   endtask

   // sender holds off until every result is back
   task automatic wait_for_results();
      while (results_seen < beats_queued) @(posedge clock);
   endtask

   task automatic queue_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      reg_writes.push_back('{index: idx, data: data});
      writes_queued++;
   endtask

   // full register setting, applied only with the pipeline empty
   task automatic set_view(int dx, int dy, int dz, int sw, int sh, int rw, int rh);
      wait_for_results();
      queue_write(CSR_DIR_X, CSR_DATA_W'(dx));
      queue_write(CSR_DIR_Y, CSR_DATA_W'(dy));
      queue_write(CSR_DIR_Z, CSR_DATA_W'(dz));
      queue_write(CSR_SCREEN_W, CSR_DATA_W'(sw));
      queue_write(CSR_SCREEN_H, CSR_DATA_W'(sh));
      queue_write(CSR_RECT_W, CSR_DATA_W'(rw));
      queue_write(CSR_RECT_H, CSR_DATA_W'(rh));
      while (writes_taken < writes_queued) @(posedge clock);
      settings_used++;
   endtask

   task automatic run_phase(int count);
      for (int i = 0; i < count; i++) queue_beat(make_matrix());
      wait_for_results();
   endtask

   // random size, extremes now and then, junk above the register bits
   function automatic int pick_size(int lo, int hi, int width);
      int v, sel;
      sel = $urandom_range(9);
      v = (sel == 0) ? lo : (sel == 1) ? hi : $urandom_range(hi, lo);
      if ($urandom_range(4) == 0) v = v | ($urandom_range(65535) << width);
      return v & 16'hFFFF;
   endfunction

   // stimulus
   initial begin
      real a, b, c, n;
      int dx, dy, dz;
      settings_used = 1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hand-picked beats at the reset setting
      queue_beat(z_beat(0, 0, 0));
      queue_beat(z_beat(0, 0, -1));
      queue_beat(z_beat(0, 0, 4096));
      queue_beat(z_beat(4096, 0, 4096));
      queue_beat(z_beat(-4096, 0, 4096));
      queue_beat(z_beat(0, 4096, 4096));
      queue_beat(z_beat(0, -4096, 4096));
      queue_beat(z_beat(4096, 4096, 4096));
      queue_beat(z_beat(-4096, -4096, 4096));
      queue_beat(z_beat(8192, 0, 4096));
      queue_beat(z_beat(0, -8192, 4096));
      queue_beat(z_beat(16, 16, 1));
      queue_beat(z_beat(17, 0, 1));
      queue_beat(z_beat(0, -17, 1));
      queue_beat(z_beat(32767, 0, 1));
      queue_beat(z_beat(-32768, -32768, 1));
      queue_beat(z_beat(32767, 32767, 32767));
      queue_beat(z_beat(-32768, -32768, -32768));
      queue_beat(z_beat(0, 0, 32767));
      queue_beat({9{16'sh7FFF}});
      queue_beat({9{16'sh8000}});
      wait_for_results();

      // zero rectangle width, then zero screen width, then zero screen and rectangle height
      set_view(0, 0, 16384, 1920, 1080, 0, 16);
      run_phase(SPECIAL_BEATS);
      set_view(0, 0, 16384, 0, 1080, 16, 16);
      run_phase(SPECIAL_BEATS);
      set_view(0, 0, 16384, 1920, 0, 16, 0);
      run_phase(SPECIAL_BEATS);
      // oversize registers fall back to the limits
      set_view(0, 0, 16384, 16'h3FFF, 16'hFFFF, 511, 16'hFFFF);
      run_phase(SPECIAL_BEATS);
      // smallest screen under the largest rectangle
      set_view(-16384, 0, 0, 16, 16, 256, 256);
      run_phase(SPECIAL_BEATS);
      // largest screen, one pixel rectangle
      set_view(0, 16384, 0, 8192, 8192, 1, 1);
      run_phase(SPECIAL_BEATS);
      // direction outside unit range, plus a write past the last register
      set_view(32767, -32768, 32767, 1920, 1080, 64, 32);
      queue_write(CSR_SPARE, 16'hFFFF);
      while (writes_taken < writes_queued) @(posedge clock);
      run_phase(SPECIAL_BEATS);

      // random settings with random beats
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // one stretch with no idling on either side
         sender_idle_pct   = (p >= 6 && p < 10) ? 0 : IDLE_PCT;
         receiver_idle_pct = sender_idle_pct;
         if ($urandom_range(5) == 0) begin
            dx = 0;
            dy = 0;
            dz = 0;
            case ($urandom_range(2))
               0: dx = $urandom_range(1) ? 16384 : -16384;
               1: dy = $urandom_range(1) ? 16384 : -16384;
               default: dz = $urandom_range(1) ? 16384 : -16384;
            endcase
         end else begin
            a = real'($urandom_range(32768)) - 16384.0;
            b = real'($urandom_range(32768)) - 16384.0;
            c = real'($urandom_range(32768)) - 16384.0;
            n = $sqrt(a * a + b * b + c * c);
            if (n < 1.0) n = 1.0;
            dx = int'(a * 16384.0 / n);
            dy = int'(b * 16384.0 / n);
            dz = int'(c * 16384.0 / n);
         end
         set_view(dx, dy, dz,
                  pick_size(16, SCREEN_LIMIT, SCR_W), pick_size(16, SCREEN_LIMIT, SCR_W),
                  pick_size(1, RECT_LIMIT, RECT_W), pick_size(1, RECT_LIMIT, RECT_W));
         run_phase(RANDOM_BEATS);
      end

      wait_for_results();
      repeat (60) @(posedge clock);

      $display("checked %0d matrix beats under %0d register settings",
               beats_accepted, settings_used);
      $display("results: %0d behind the viewer, %0d clamped ratios, %0d partly visible",
               behind_count, clamp_count, partial_count);
      if (error_count == 0 && expected_views.size() == 0) begin
         $display("[projected_rect_visible_fraction_top] OK");
      end else begin
         if (expected_views.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expected_views.size());
         $display("[projected_rect_visible_fraction_top] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
src/prvf_pkg.sv
src/projected_rect_visible_fraction_top.sv
bench/tb_projected_rect_visible_fraction_top.sv
